FILE: sv/alim_pkg.sv
// ---------------------------------------------------------------------------
// alim_pkg
// Shared types and codes for the positional-insert list block.
// ---------------------------------------------------------------------------
package alim_pkg;

   localparam int FUNC_W = 2;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 5;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 40;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [VAL_W-1:0]  val_type;
   typedef logic [ST_W-1:0]   status_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // operation codes
   localparam func_type FUNC_INSERT   = 2'd0;
   localparam func_type FUNC_MODIFY   = 2'd1;
   localparam func_type FUNC_TRAVERSE = 2'd2;

   // status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_BADIDX = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   // one result item
   typedef struct packed {
      status_type status;
      pos_type    out_position;
      val_type    out_value;
      logic       last;
   } rsp_type;

   // result offered by the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } push_type;

endpackage

FILE: sv/alim_ram.sv
// ---------------------------------------------------------------------------
// alim_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module alim_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/alim_seq.sv
// ---------------------------------------------------------------------------
// alim_seq
// Request sequencer: checks, shifts entries through the RAM, walks traverse.
// ---------------------------------------------------------------------------
module alim_seq #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  alim_pkg::func_type  req_func,
   input  alim_pkg::pos_type   req_position,
   input  alim_pkg::val_type   req_value,
   output alim_pkg::push_type  push,
   input  logic                out_free,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output alim_pkg::val_type   wr_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  alim_pkg::val_type   rd_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_PUT   = 3'd2;
   localparam logic [2:0] S_RESP  = 3'd3;
   localparam logic [2:0] S_TRAV  = 3'd4;

   localparam alim_pkg::cnt_type CNT_ONE = alim_pkg::CNT_W'(1);
   localparam alim_pkg::cnt_type CNT_CAP = alim_pkg::CNT_W'(CAPACITY);

   logic [2:0]           state_ff, state_in;
   alim_pkg::cnt_type    count_ff, count_in;
   alim_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [AW-1:0]        wsrc_ff, wsrc_in;
   logic [AW-1:0]        tgt_ff, tgt_in;
   alim_pkg::val_type    val_ff, val_in;
   logic                 rv_ff, rv_in;
   logic                 idone_ff, idone_in;
   alim_pkg::cnt_type    rcnt_ff, rcnt_in;
   alim_pkg::cnt_type    ecnt_ff, ecnt_in;
   logic                 pend_ff, pend_in;

   logic                 accept;
   logic                 full;
   logic                 ins_bad;
   logic                 mod_bad;
   logic [AW-1:0]        pos_addr;
   alim_pkg::cnt_type    ecnt_next;
   logic                 load;
   logic                 issue;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= CNT_CAP);
   assign ins_bad   = (req_position == '0) ||
                      ({1'b0, req_position} > ({1'b0, count_ff} + 6'd1));
   assign mod_bad   = (req_position == '0) || (req_position > count_ff);
   assign pos_addr  = AW'(req_position - CNT_ONE);
   assign ecnt_next = ecnt_ff + CNT_ONE;
   assign load      = (state_ff == S_TRAV) && pend_ff && out_free;
   assign issue     = (state_ff == S_TRAV) && (rcnt_ff < count_ff) && (!pend_ff || load);

   // next-state and datapath control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      src_in    = src_ff;
      wsrc_in   = wsrc_ff;
      tgt_in    = tgt_ff;
      val_in    = val_ff;
      rv_in     = 1'b0;
      idone_in  = idone_ff;
      rcnt_in   = rcnt_ff;
      ecnt_in   = ecnt_ff;
      pend_in   = pend_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_addr;
      wr_data   = req_value;
      rd_en     = 1'b0;
      rd_addr   = src_ff;
      push      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RESP;
               case (req_func)
                  alim_pkg::FUNC_INSERT: begin
                     if (full) begin
                        status_in = alim_pkg::ST_FULL;
                     end else if (ins_bad) begin
                        status_in = alim_pkg::ST_BADIDX;
                     end else begin
                        status_in = alim_pkg::ST_OK;
                        count_in  = count_ff + CNT_ONE;
                        if (req_position == count_in) begin
                           // append at the tail, nothing to move
                           wr_en = 1'b1;
                        end else begin
                           state_in = S_SHIFT;
                           src_in   = AW'(count_ff - CNT_ONE);
                           tgt_in   = pos_addr;
                           val_in   = req_value;
                           idone_in = 1'b0;
                        end
                     end
                  end
                  alim_pkg::FUNC_MODIFY: begin
                     if (count_ff == '0) begin
                        status_in = alim_pkg::ST_EMPTY;
                     end else if (mod_bad) begin
                        status_in = alim_pkg::ST_BADIDX;
                     end else begin
                        status_in = alim_pkg::ST_OK;
                        wr_en     = 1'b1;
                     end
                  end
                  alim_pkg::FUNC_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = alim_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_TRAV;
                        rcnt_in  = '0;
                        ecnt_in  = '0;
                        pend_in  = 1'b0;
                     end
                  end
                  default: begin
                     status_in = alim_pkg::ST_OK;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // read entry src, write it one place up on the next cycle
            if (!idone_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               rv_in   = 1'b1;
               wsrc_in = src_ff;
               if (src_ff == tgt_ff) begin
                  idone_in = 1'b1;
               end else begin
                  src_in = src_ff - AW'(1);
               end
            end
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = wsrc_ff + AW'(1);
               wr_data = rd_data;
            end
            if (idone_ff && rv_ff) begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_data  = val_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            push.valid            = 1'b1;
            push.rsp.status       = status_ff;
            push.rsp.out_position = '0;
            push.rsp.out_value    = '0;
            push.rsp.last         = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         S_TRAV: begin
            // one read in flight, data held by the RAM until handed over
            push.valid            = pend_ff;
            push.rsp.status       = alim_pkg::ST_OK;
            push.rsp.out_position = alim_pkg::POS_W'(ecnt_next);
            push.rsp.out_value    = rd_data;
            push.rsp.last         = (ecnt_next == count_ff);
            if (issue) begin
               rd_en   = 1'b1;
               rd_addr = rcnt_ff[AW-1:0];
               rcnt_in = rcnt_ff + CNT_ONE;
            end
            pend_in = issue || (pend_ff && !load);
            if (load) begin
               ecnt_in = ecnt_next;
               if (ecnt_next == count_ff) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         idone_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         idone_ff <= idone_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      src_ff    <= src_in;
      wsrc_ff   <= wsrc_in;
      tgt_ff    <= tgt_in;
      val_ff    <= val_in;
      rcnt_ff   <= rcnt_in;
      ecnt_ff   <= ecnt_in;
   end

endmodule

FILE: sv/array_list_insert_modify_top.sv
// ---------------------------------------------------------------------------
// array_list_insert_modify_top
// Ordered list of signed 32-bit values with insert, modify and traverse.
// ---------------------------------------------------------------------------
// The list lives in one RAM of CAPACITY words with a registered read; one
// request is worked at a time. Modify, a rejected insert and an insert at
// the tail go from the request straight to the result. An insert at
// position p into a list of n entries moves n-p+1 entries through the RAM,
// one read and one write a cycle. Traverse streams one result a cycle once
// the first RAM read is started, when the result side keeps up. Every
// request ends in at least one result, the final one marked with tlast.
// No clearing pass is needed after reset.
module array_list_insert_modify_top #(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // func [1:0], position [6:2], value [38:7], zero [39]
   input  logic [alim_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status [1:0], out_position [6:2], out_value [38:7], zero [39]
   output logic [alim_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   alim_pkg::push_type push;
   logic               out_free;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   alim_pkg::val_type  wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   alim_pkg::val_type  rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   alim_pkg::rsp_type  rsp_ff, rsp_in;

   alim_ram #(
      .WIDTH (alim_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   alim_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_func     (req_tdata[1:0]),
      .req_position (req_tdata[6:2]),
      .req_value    (req_tdata[38:7]),
      .push         (push),
      .out_free     (out_free),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   // output register, refilled in the cycle it drains
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = push.valid;
         rsp_in       = push.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.out_value, rsp_ff.out_position, rsp_ff.status};
   assign rsp_tlast  = rsp_ff.last;

endmodule
